// ===== rtl/alpha_premultiply_convert_macros.svh =====
// assertion macros for the alpha premultiply converter
`ifndef ALPHA_PREMULTIPLY_CONVERT_MACROS_SVH
`define ALPHA_PREMULTIPLY_CONVERT_MACROS_SVH

`ifndef SYNTHESIS
`define APC_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("apc assertion failed");
`define APC_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("apc assertion failed");
`else
`define APC_ASSERT(name, prop)
`define APC_ASSERT_ALWAYS(name, prop)
`endif

`endif

// ===== rtl/apc_pkg.sv =====
// shared types, constants and binary16 helpers for the alpha converter
package apc_pkg;

  localparam int NumWork = 8;
  localparam int NumStg  = NumWork + 1;

  localparam logic [15:0] HalfOne  = 16'h3C00;
  localparam logic [15:0] HalfZero = 16'h0000;
  localparam logic [4:0]  ExpMax   = 5'h1F;

  typedef struct packed {
    logic               div;
    logic               spec;
    logic [15:0]        spec_val;
    logic signed [8:0]  xe;
    logic [10:0]        den;
    logic [11:0]        rem;
    logic [13:0]        quo;
    logic [21:0]        prod;
  } apc_work_t;

  typedef struct packed {
    logic        zero_all;
    logic [15:0] alpha;
  } apc_side_t;

  function automatic logic [3:0] lzc11(input logic [10:0] m);
    logic [3:0] n;
    n = 4'd11;
    for (int i = 0; i < 11; i++) begin
      if (m[i]) n = 4'(10 - i);
    end
    return n;
  endfunction

  function automatic logic [15:0] alpha_clamp(input logic [15:0] a);
    logic [15:0] r;
    if (a[14:10] == ExpMax && a[9:0] != 10'd0) r = HalfZero;
    else if (a[15] || a[14:0] == 15'd0) r = HalfZero;
    else if (a[14:10] >= 5'd15) r = HalfOne;
    else r = a;
    return r;
  endfunction

  function automatic apc_work_t lane_setup(input logic [15:0] c, input logic [15:0] a,
                                           input logic div);
    logic cnan, cinf, czero, anan, ainf, azero, neg, nan_r, hit_one;
    logic [10:0] cm, am;
    logic [3:0] cl, al;
    logic signed [8:0] cx, ax;
    apc_work_t w;
    cnan  = (c[14:10] == ExpMax) && (c[9:0] != 10'd0);
    cinf  = (c[14:10] == ExpMax) && (c[9:0] == 10'd0);
    czero = (c[14:0] == 15'd0);
    anan  = (a[14:10] == ExpMax) && (a[9:0] != 10'd0);
    ainf  = (a[14:10] == ExpMax) && (a[9:0] == 10'd0);
    azero = (a[14:0] == 15'd0);
    neg   = c[15] ^ a[15];
    cm = {c[14:10] != 5'd0, c[9:0]};
    am = {a[14:10] != 5'd0, a[9:0]};
    cl = lzc11(cm);
    al = lzc11(am);
    cm = cm << cl;
    am = am << al;
    cx = ((c[14:10] == 5'd0) ? 9'sd1 : $signed({4'b0, c[14:10]}))
         - 9'sd15 - $signed({5'b0, cl});
    ax = ((a[14:10] == 5'd0) ? 9'sd1 : $signed({4'b0, a[14:10]}))
         - 9'sd15 - $signed({5'b0, al});
    if (div) begin
      nan_r   = cnan | anan | (cinf & ainf);
      hit_one = !nan_r && !czero && !neg && !ainf && (cinf || azero);
    end else begin
      nan_r   = cnan | anan | (cinf & azero) | (czero & ainf);
      hit_one = !nan_r && !czero && !azero && !neg && (cinf || ainf);
    end
    w.div      = div;
    w.spec     = cnan | anan | cinf | ainf | czero | azero | neg;
    w.spec_val = hit_one ? HalfOne : HalfZero;
    w.xe       = div ? (cx - ax) : (cx + ax);
    w.den      = am;
    w.rem      = {1'b0, cm};
    w.quo      = '0;
    w.prod     = '0;
    return w;
  endfunction

  function automatic logic [15:0] round_half(input apc_work_t w);
    logic signed [8:0] x, dd;
    logic [23:0] sig, sh;
    logic [47:0] wide;
    logic st, g, up;
    logic [11:0] t;
    logic [5:0] d;
    logic [4:0] ef;
    logic [15:0] r;
    if (w.div) begin
      if (w.quo[13]) begin
        x = w.xe;
        sig = {w.quo, 10'b0};
      end else begin
        x = w.xe - 9'sd1;
        sig = {w.quo[12:0], 11'b0};
      end
      st = (w.rem != 12'd0);
    end else begin
      if (w.prod[21]) begin
        x = w.xe + 9'sd1;
        sig = {w.prod, 2'b0};
      end else begin
        x = w.xe;
        sig = {w.prod[20:0], 3'b0};
      end
      st = 1'b0;
    end
    dd = -9'sd14 - x;
    if (x < -9'sd14) begin
      d    = (dd > 9'sd25) ? 6'd25 : dd[5:0];
      wide = {sig, 24'b0} >> d;
      sh   = wide[47:24];
      st   = st | (|wide[23:0]);
      ef   = 5'd0;
    end else begin
      sh = sig;
      ef = 5'(x + 9'sd15);
    end
    t  = {1'b0, sh[23:13]};
    g  = sh[12];
    st = st | (|sh[11:0]);
    up = g & (st | t[0]);
    t  = t + {11'b0, up};
    r  = {1'b0, ef, 10'b0} + {4'b0, t};
    if (ef != 5'd0) r = r - 16'h0400;
    if (w.spec) r = w.spec_val;
    else if (x >= 9'sd0) r = HalfOne;
    return r;
  endfunction

endpackage

// ===== rtl/apc_lane.sv =====
// one color lane: operand setup, multiply or radix-4 divide, rounding
module apc_lane (
  input  logic                        clk_i,
  input  logic [apc_pkg::NumStg-1:0]  en_i,
  input  logic                        div_i,
  input  logic [15:0]                 chan_i,
  input  logic [15:0]                 alpha_i,
  output logic [15:0]                 res_o
);

  apc_pkg::apc_work_t st_q [apc_pkg::NumWork];
  apc_pkg::apc_work_t st_d [apc_pkg::NumWork];
  logic [15:0]        res_q;

  // two restoring quotient bits per stage
  function automatic apc_pkg::apc_work_t div2(input apc_pkg::apc_work_t w);
    apc_pkg::apc_work_t o;
    logic [11:0] r, r2;
    logic ge;
    o = w;
    r = w.rem;
    for (int j = 0; j < 2; j++) begin
      ge = (r >= {1'b0, w.den});
      r2 = ge ? (r - {1'b0, w.den}) : r;
      o.quo = {o.quo[12:0], ge};
      r = {r2[10:0], 1'b0};
    end
    o.rem = r;
    return o;
  endfunction

  always_comb begin
    st_d[0] = apc_pkg::lane_setup(chan_i, alpha_i, div_i);
    for (int k = 1; k < apc_pkg::NumWork; k++) begin
      st_d[k] = div2(st_q[k-1]);
    end
    st_d[1].prod = {11'b0, st_q[0].rem[10:0]} * {11'b0, st_q[0].den};
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < apc_pkg::NumWork; k++) begin
      if (en_i[k]) st_q[k] <= st_d[k];
    end
    if (en_i[apc_pkg::NumWork]) res_q <= apc_pkg::round_half(st_q[apc_pkg::NumWork-1]);
  end

  assign res_o = res_q;

endmodule

// ===== rtl/apc_merge.sv =====
// merges the color lanes with the alpha side path into one pixel
module apc_merge (
  input  logic [15:0]        red_i,
  input  logic [15:0]        green_i,
  input  logic [15:0]        blue_i,
  input  apc_pkg::apc_side_t side_i,
  output logic [15:0]        red_o,
  output logic [15:0]        green_o,
  output logic [15:0]        blue_o,
  output logic [15:0]        alpha_o
);

  always_comb begin
    if (side_i.zero_all) begin
      red_o   = apc_pkg::HalfZero;
      green_o = apc_pkg::HalfZero;
      blue_o  = apc_pkg::HalfZero;
      alpha_o = apc_pkg::HalfZero;
    end else begin
      red_o   = red_i;
      green_o = green_i;
      blue_o  = blue_i;
      alpha_o = side_i.alpha;
    end
  end

endmodule

// ===== rtl/alpha_premultiply_convert.sv =====
// top level: binary16 rgba premultiply / unpremultiply with clamp to [0,1]
//
// input channel: valid_i, stall_o and req_type_i plus the four binary16
// channels; a transaction happens when valid_i is high and stall_o low.
// output channel: valid_o, stall_i and the four clamped binary16 results.
// one result leaves for each input transaction, in order.
// three identical color lanes run side by side; each holds an 11x11
// multiplier and a seven-stage radix-4 restoring divider, and alpha
// travels on a side path. a combinational merge applies the transparent-alpha
// zeroing, then an output register holds the pixel.
// throughput is one pixel per cycle while the pipeline is not stalled, as
// the divider pipeline is fully staged.
// each stage advances when the stage after it is empty or moving, so the
// block keeps taking pixels into empty stages while a result waits on
// stall_i; stall_o rises only when every stage holds a pixel.
// reset empties all stages; valid_o is low afterwards.
`include "alpha_premultiply_convert_macros.svh"
module alpha_premultiply_convert (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic        req_type_i,
  input  logic [15:0] red_in_i,
  input  logic [15:0] green_in_i,
  input  logic [15:0] blue_in_i,
  input  logic [15:0] alpha_in_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [15:0] red_out_o,
  output logic [15:0] green_out_o,
  output logic [15:0] blue_out_o,
  output logic [15:0] alpha_out_o
);

  logic [apc_pkg::NumStg-1:0] v_q;
  logic [apc_pkg::NumStg:0]   rdy;
  logic                       out_v_q;
  apc_pkg::apc_side_t         side_q [apc_pkg::NumStg];
  apc_pkg::apc_side_t         side_d;
  logic [15:0]                chan [3];
  logic [15:0]                lane_res [3];
  logic [15:0] red_m, green_m, blue_m, alpha_m;
  logic [15:0] red_q, green_q, blue_q, alpha_q;

  always_comb begin
    rdy[apc_pkg::NumStg] = !out_v_q || !stall_i;
    for (int k = apc_pkg::NumStg - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign stall_o = !rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (rdy[0]) v_q[0] <= valid_i;
      for (int k = 1; k < apc_pkg::NumStg; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
      if (rdy[apc_pkg::NumStg]) out_v_q <= v_q[apc_pkg::NumStg-1];
    end
  end

  // alpha at or below zero wipes the whole pixel when unpremultiplying
  always_comb begin
    side_d.zero_all = req_type_i
                      && !(alpha_in_i[14:10] == apc_pkg::ExpMax && alpha_in_i[9:0] != 10'd0)
                      && (alpha_in_i[15] || alpha_in_i[14:0] == 15'd0);
    side_d.alpha = apc_pkg::alpha_clamp(alpha_in_i);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) side_q[0] <= side_d;
    for (int k = 1; k < apc_pkg::NumStg; k++) begin
      if (rdy[k]) side_q[k] <= side_q[k-1];
    end
  end

  assign chan[0] = red_in_i;
  assign chan[1] = green_in_i;
  assign chan[2] = blue_in_i;

  for (genvar l = 0; l < 3; l++) begin : g_lane
    apc_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (rdy[apc_pkg::NumStg-1:0]),
      .div_i   (req_type_i),
      .chan_i  (chan[l]),
      .alpha_i (alpha_in_i),
      .res_o   (lane_res[l])
    );
  end

  apc_merge u_merge (
    .red_i   (lane_res[0]),
    .green_i (lane_res[1]),
    .blue_i  (lane_res[2]),
    .side_i  (side_q[apc_pkg::NumStg-1]),
    .red_o   (red_m),
    .green_o (green_m),
    .blue_o  (blue_m),
    .alpha_o (alpha_m)
  );

  always_ff @(posedge clk_i) begin
    if (rdy[apc_pkg::NumStg]) begin
      red_q   <= red_m;
      green_q <= green_m;
      blue_q  <= blue_m;
      alpha_q <= alpha_m;
    end
  end

  assign valid_o     = out_v_q;
  assign red_out_o   = red_q;
  assign green_out_o = green_q;
  assign blue_out_o  = blue_q;
  assign alpha_out_o = alpha_q;

  `APC_ASSERT(a_empty_no_stall, !valid_o |-> !stall_o)
  `APC_ASSERT(a_accept_enters, (valid_i && !stall_o) |=> v_q[0])
  `APC_ASSERT(a_result_range, valid_o |-> (red_out_o <= apc_pkg::HalfOne
    && green_out_o <= apc_pkg::HalfOne && blue_out_o <= apc_pkg::HalfOne
    && alpha_out_o <= apc_pkg::HalfOne))
  `APC_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !valid_o)

endmodule
